### rtl/sfr_pkg.sv
// Shared constants and types for the serial frame receiver.
// No dependencies; imported by every module of the block.
`default_nettype none

package sfr_pkg;

  localparam int BYTE_W               = 8;
  localparam int POS_OUT_W            = 6;
  localparam int FRAME_LENGTH_DEFAULT = 10;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_HEADER  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_HEADER = CFG_IDX_W'(1);

  localparam logic [BYTE_W-1:0] FIRST_HEADER_RESET  = 8'hAA;
  localparam logic [BYTE_W-1:0] SECOND_HEADER_RESET = 8'hBB;

  // Back end hands a frame buffer bank back to the front end
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

endpackage

`default_nettype wire

### rtl/sfr_front.sv
// Front end: header match, running sum, frame buffer writes, bank ownership.
// Depends on sfr_pkg.
`default_nettype none

module sfr_front #(
  parameter int FRAME_LENGTH = sfr_pkg::FRAME_LENGTH_DEFAULT,
  parameter int PW           = $clog2(FRAME_LENGTH)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           rx_valid,
  output logic                           rx_ready,
  input  logic [sfr_pkg::BYTE_W-1:0]     rx_byte,
  output logic                           wr_en,
  output logic [PW:0]                    wr_addr,
  output logic [sfr_pkg::BYTE_W-1:0]     wr_data,
  output logic                           push,
  output logic                           push_bank,
  input  sfr_pkg::release_t              release_in
);
  import sfr_pkg::*;

  localparam logic [PW-1:0] LAST_POS = PW'(FRAME_LENGTH - 1);

  logic [BYTE_W-1:0] first_header;
  logic [BYTE_W-1:0] second_header;
  logic [PW-1:0]     position, position_next;
  logic [BYTE_W-1:0] running_sum, running_sum_next;
  logic              wr_bank;
  logic [1:0]        busy, busy_next;
  logic              accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_header  <= FIRST_HEADER_RESET;
      second_header <= SECOND_HEADER_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIRST_HEADER:  first_header  <= cfg_data;
        REG_SECOND_HEADER: second_header <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rx_ready  = !busy[wr_bank];
  assign accept    = rx_valid && rx_ready;
  assign wr_en     = accept;
  assign wr_addr   = {wr_bank, position};
  assign wr_data   = rx_byte;
  assign push_bank = wr_bank;

  always_comb begin
    position_next    = position;
    running_sum_next = running_sum;
    push             = 1'b0;
    if (accept) begin
      running_sum_next = running_sum + rx_byte;
      if (position == '0 && rx_byte == first_header) begin
        position_next = PW'(1);
      end else if (position == PW'(1) && rx_byte == second_header) begin
        position_next = PW'(2);
      end else if (position >= PW'(2) && position < LAST_POS) begin
        position_next = position + PW'(1);
      end else if (position == LAST_POS && rx_byte == running_sum) begin
        push             = 1'b1;
        position_next    = '0;
        running_sum_next = '0;
      end else begin
        position_next    = '0;
        running_sum_next = '0;
      end
    end
  end

  always_comb begin
    busy_next = busy;
    if (push)             busy_next[wr_bank]         = 1'b1;
    if (release_in.valid) busy_next[release_in.bank] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= '0;
      running_sum <= '0;
      wr_bank     <= 1'b0;
      busy        <= '0;
    end else begin
      position    <= position_next;
      running_sum <= running_sum_next;
      busy        <= busy_next;
      if (push) wr_bank <= !wr_bank;
    end
  end

endmodule

`default_nettype wire

### rtl/sfr_cmd_queue.sv
// Two-entry queue of completed frame bank numbers between front and back end.
// Depends on sfr_pkg only for the house import.
`default_nettype none

module sfr_cmd_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic push_bank,
  input  logic pop,
  output logic cmd_valid,
  output logic cmd_bank
);
  import sfr_pkg::*;

  logic [1:0] slot;
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;

  assign cmd_valid = (count != 2'd0);
  assign cmd_bank  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_bank;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: ;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> count != 2'd2)
    else $error("frame queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != 2'd0)
    else $error("frame queue underflow");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 2'd1)
    else $error("frame queue count did not advance");

endmodule

`default_nettype wire

### rtl/sfr_back.sv
// Back end: double-banked frame buffer memory and the frame drain sequencer.
// Depends on sfr_pkg.
`default_nettype none

module sfr_back #(
  parameter int FRAME_LENGTH = sfr_pkg::FRAME_LENGTH_DEFAULT,
  parameter int PW           = $clog2(FRAME_LENGTH)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [PW:0]                   wr_addr,
  input  logic [sfr_pkg::BYTE_W-1:0]    wr_data,
  input  logic                          cmd_valid,
  input  logic                          cmd_bank,
  output logic                          cmd_pop,
  output sfr_pkg::release_t             release_out,
  output logic                          frame_valid,
  input  logic                          frame_ready,
  output logic [sfr_pkg::BYTE_W-1:0]    frame_byte,
  output logic [sfr_pkg::POS_OUT_W-1:0] byte_position,
  output logic                          last_byte
);
  import sfr_pkg::*;

  localparam int            DEPTH    = 2 ** (PW + 1);
  localparam logic [PW-1:0] LAST_POS = PW'(FRAME_LENGTH - 1);

  logic [BYTE_W-1:0] mem [DEPTH];

  logic              active;
  logic              bank;
  logic [PW-1:0]     rd_pos;
  logic              issue;
  logic              issue_last;

  // Read stage: registered memory data plus its position tag
  logic              p_valid;
  logic [BYTE_W-1:0] p_data;
  logic [PW-1:0]     p_pos;
  logic              p_last;
  logic              move;

  assign move       = p_valid && (!frame_valid || frame_ready);
  assign issue      = active && (!p_valid || move);
  assign issue_last = (rd_pos == LAST_POS);
  assign cmd_pop    = !active && cmd_valid;

  assign release_out.valid = issue && issue_last;
  assign release_out.bank  = bank;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p_data <= mem[{bank, rd_pos}];
      p_pos  <= rd_pos;
      p_last <= issue_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      bank    <= 1'b0;
      rd_pos  <= '0;
      p_valid <= 1'b0;
    end else begin
      if (cmd_pop) begin
        active <= 1'b1;
        bank   <= cmd_bank;
        rd_pos <= '0;
      end else if (issue) begin
        if (issue_last) active <= 1'b0;
        rd_pos <= rd_pos + PW'(1);
      end
      if (issue)     p_valid <= 1'b1;
      else if (move) p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (move) begin
      frame_valid <= 1'b1;
    end else if (frame_ready) begin
      frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      frame_byte    <= p_data;
      byte_position <= POS_OUT_W'(p_pos);
      last_byte     <= p_last;
    end
  end

  a_last_at_end: assert property (@(posedge clk) disable iff (rst)
    frame_valid && last_byte |-> byte_position == POS_OUT_W'(FRAME_LENGTH - 1))
    else $error("last byte flagged away from frame end");

  a_pop_when_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> !issue && !p_valid || !active)
    else $error("frame popped while a drain is running");

  a_read_stage_holds: assert property (@(posedge clk) disable iff (rst)
    p_valid && !move |=> p_valid && $stable(p_pos))
    else $error("read stage lost an item under stall");

  a_drain_in_order: assert property (@(posedge clk) disable iff (rst)
    move && p_pos != '0 && frame_valid |-> p_pos == PW'(byte_position) + PW'(1))
    else $error("frame bytes out of order");

endmodule

`default_nettype wire

### rtl/serial_frame_receiver.sv
// Top level of the serial frame receiver: front end, frame queue, back end.
// Depends on sfr_pkg, sfr_front, sfr_cmd_queue and sfr_back.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+--------------------------------------
//   rx       | rx_valid / rx_ready         | rx_byte[7:0]
//   frame    | frame_valid / frame_ready   | frame_byte[7:0], byte_position[5:0],
//            |                             | last_byte
//   config   | cfg_we (no wait)            | cfg_index[1:0], cfg_data[7:0]
//
// One rx item is taken every cycle while the bank being filled is free; two banks
// let one frame drain while the next one fills.
// A checked frame leaves as FRAME_LENGTH items, one per cycle while frame_ready is
// high; after the checksum byte is taken, the first passes queue pop, memory read
// and output register. Each drain holds the back end longer than a frame takes to
// fill and frees its bank only at its last read, so back-to-back frames stall rx
// from the third frame on even with frame_ready high; a held-off frame_ready fills
// both banks and keeps rx_ready low until the sink takes items again.
// Synchronous reset clears the position, sum, bank ownership and queue; the
// frame buffer needs no clearing since a frame is drained only once fully written.
`default_nettype none

module serial_frame_receiver #(
  parameter int FRAME_LENGTH = sfr_pkg::FRAME_LENGTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          rx_valid,
  output logic                          rx_ready,
  input  logic [sfr_pkg::BYTE_W-1:0]    rx_byte,
  output logic                          frame_valid,
  input  logic                          frame_ready,
  output logic [sfr_pkg::BYTE_W-1:0]    frame_byte,
  output logic [sfr_pkg::POS_OUT_W-1:0] byte_position,
  output logic                          last_byte
);
  import sfr_pkg::*;

  // Position counter width; the buffer address adds one bank bit on top
  localparam int PW = $clog2(FRAME_LENGTH);

  // Frame buffer write port, driven by the front end
  logic              wr_en;
  logic [PW:0]       wr_addr;
  logic [BYTE_W-1:0] wr_data;

  // Completed frames travel as bank numbers through the queue
  logic     push;
  logic     push_bank;
  logic     cmd_valid;
  logic     cmd_bank;
  logic     cmd_pop;
  release_t bank_release;

  // Match headers, accumulate the sum and store each byte
  sfr_front #(
    .FRAME_LENGTH (FRAME_LENGTH),
    .PW           (PW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .rx_valid   (rx_valid),
    .rx_ready   (rx_ready),
    .rx_byte    (rx_byte),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .push       (push),
    .push_bank  (push_bank),
    .release_in (bank_release)
  );

  // Hold finished frames until the back end is free
  sfr_cmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_bank (push_bank),
    .pop       (cmd_pop),
    .cmd_valid (cmd_valid),
    .cmd_bank  (cmd_bank)
  );

  // Drain each finished frame from its bank, one byte per cycle while frame_ready is high
  sfr_back #(
    .FRAME_LENGTH (FRAME_LENGTH),
    .PW           (PW)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .cmd_valid     (cmd_valid),
    .cmd_bank      (cmd_bank),
    .cmd_pop       (cmd_pop),
    .release_out   (bank_release),
    .frame_valid   (frame_valid),
    .frame_ready   (frame_ready),
    .frame_byte    (frame_byte),
    .byte_position (byte_position),
    .last_byte     (last_byte)
  );

endmodule

`default_nettype wire
